FILE: sv/fde_pkg.sv
`timescale 1ns / 1ps

package fde_pkg;

  // Configuration port geometry and register widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int DECAY_W    = 7;
  localparam int DELAY_W    = 16;
  localparam int WARM_W     = 16;

  // Fixed-point constants of the echo arithmetic.
  localparam int GAIN_SHIFT = 14;
  localparam int DIVISOR    = 100;

  // Register limits and reset values.
  localparam logic [GAIN_W-1:0]  GAIN_MAX    = 16'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
  localparam logic [DECAY_W-1:0] DECAY_MAX   = 7'd99;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 7'd10;
  localparam int                 DELAY_RESET = 9600;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 2'd0,
    CFG_DECAY = 2'd1,
    CFG_DELAY = 2'd2
  } cfg_idx_e;

  // Operations of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_RECIP,
    MUL_GAIN
  } mul_op_e;

endpackage

FILE: sv/fde_ram.sv
`timescale 1ns / 1ps

module fde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/fde_mul.sv
`timescale 1ns / 1ps

module fde_mul #(
  parameter int SUM_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  fde_pkg::mul_op_e                  op_i,
  input  logic signed [SUM_BITS-1:0]        stored_i,
  input  logic [fde_pkg::DECAY_W-1:0]       decay_i,
  input  logic [SUM_BITS+5:0]               mag_i,
  input  logic signed [SUM_BITS-1:0]        sum_i,
  input  logic [fde_pkg::GAIN_W-1:0]        gain_i,
  output logic signed [2*SUM_BITS+7:0]      p_o
);
  import fde_pkg::*;

  localparam int MAG_W = SUM_BITS + 6;
  localparam int A_W   = SUM_BITS + 7;
  localparam int B_W   = SUM_BITS + 1;
  localparam int P_W   = A_W + B_W;

  // Reciprocal of the divisor, floor(2^MAG_W / 100); the caller corrects by one step.
  localparam longint          RECIP_L = (longint'(1) << MAG_W) / DIVISOR;
  localparam logic [B_W-1:0]  RECIP   = B_W'(RECIP_L);

  logic signed [A_W-1:0] a;
  logic signed [B_W-1:0] b;
  logic signed [P_W-1:0] p_q;

  // Operand selection for the three uses of the multiplier.
  always_comb begin
    case (op_i)
      MUL_DECAY: begin
        a = A_W'(stored_i);
        b = signed'(B_W'(decay_i));
      end
      MUL_RECIP: begin
        a = signed'(A_W'(mag_i));
        b = signed'(RECIP);
      end
      MUL_GAIN: begin
        a = A_W'(sum_i);
        b = signed'(B_W'(gain_i));
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // Product register; it holds while the unit is not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a * b;
    end
  end

  assign p_o = p_q;

endmodule

FILE: sv/feedback_delay_echo_core.sv
`timescale 1ns / 1ps

// Feedback echo on a stream of signed audio samples.
// Input channel in_valid_i/in_ready_o carries one sample word; output channel
// out_valid_o/out_ready_i returns one echoed word with a clip flag for each input.
// The cfg channel writes gain, decay percent and delay (index 0, 1, 2); any
// valid index restarts warm-up, an unknown index is taken and ignored.
// Once warm-up is over a word runs through the scale, reciprocal, fix, sum,
// gain and limit states, during warm-up through sum, gain and limit only; no
// new word is taken before the last leaves the limit state. The one shared
// multiplier serves the decay product, the reciprocal divide by 100 and the
// gain, with a correction step for the divide and a saturating add before the gain.
// The echo memory is read once and written once per word.
// Reset clears the write pointer and warm-up count and loads the default
// registers; the echo memory is not cleared, since warm-up keeps every read
// on entries written since the last restart.
// A stalled receiver holds the result in the output register; the block takes
// the next word meanwhile and waits before its own result if still stalled.
module feedback_delay_echo_core #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fde_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_o,
  output logic                              clipped_o
);
  import fde_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int SW    = SUM_BITS;
  localparam int MAG_W = SW + 6;
  localparam int P_W   = 2 * SW + 8;
  localparam int EXT_W = ((SAMPLE_BITS > SW) ? SAMPLE_BITS : SW) + 1;

  localparam int DELAY_INIT = (DELAY_RESET >= STORE_DEPTH) ? STORE_DEPTH - 1 : DELAY_RESET;

  localparam longint SUM_HI_L = (longint'(1) << (SW - 1)) - 1;
  localparam longint OUT_HI_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint CLIP_L   = ((longint'(1) << (SAMPLE_BITS - 1)) * 999) / 1000;

  localparam logic signed [EXT_W-1:0] SUM_HI = EXT_W'(SUM_HI_L);
  localparam logic signed [EXT_W-1:0] SUM_LO = EXT_W'(-SUM_HI_L - 1);
  localparam logic signed [P_W-1:0]   OUT_HI = P_W'(OUT_HI_L);
  localparam logic signed [P_W-1:0]   OUT_LO = P_W'(-OUT_HI_L - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_RECIP,
    S_FIX,
    S_SUM,
    S_GAIN,
    S_LIMIT
  } state_e;

  state_e                   state_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [DECAY_W-1:0]       decay_q;
  logic [DELAY_W-1:0]       delay_q;
  logic [AW-1:0]            wp_q;
  logic [WARM_W-1:0]        warmup_q;
  logic                     warm_q;
  logic                     out_valid_q;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [MAG_W-1:0]              mag_q;
  logic                          neg_q;
  logic signed [SW-1:0]          fb_q;
  logic signed [SW-1:0]          sum_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          clipped_q;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_load;
  logic                  warm_now;
  logic [AW:0]           wp_ext;
  logic [AW:0]           d_ext;
  logic [AW:0]           raddr_ext;
  logic [AW-1:0]         raddr;
  logic [SW-1:0]         rdata;
  logic                  ram_we;

  logic                  mul_en;
  mul_op_e               mul_op;
  logic signed [P_W-1:0] p;

  logic signed [SW+7:0]  p_low;
  logic [MAG_W-1:0]      mag_now;
  logic [SW-1:0]         q0;
  logic [MAG_W-1:0]      q0_x100;
  logic [MAG_W-1:0]      rem_raw;
  logic [MAG_W-1:0]      rem_fix;
  logic                  adj;
  logic [SW-1:0]         q_fix;
  logic signed [SW-1:0]  fb_d;

  logic signed [EXT_W-1:0] sum_ext;
  logic signed [SW-1:0]    sum_sat;

  logic signed [P_W-1:0]         out_sh;
  logic signed [SAMPLE_BITS-1:0] out_val;
  logic                          out_clip;

  logic [GAIN_W-1:0]  gain_wr;
  logic [DECAY_W-1:0] decay_wr;
  logic [DELAY_W-1:0] delay_wr;

  // Handshakes: configuration has priority over a new sample.
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_LIMIT) && (!out_valid_q || out_ready_i);

  // Register writes are clamped into their legal ranges.
  always_comb begin
    gain_wr  = (cfg_data_i[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : cfg_data_i[GAIN_W-1:0];
    decay_wr = (cfg_data_i[DECAY_W-1:0] > DECAY_MAX) ? DECAY_MAX : cfg_data_i[DECAY_W-1:0];
    if (cfg_data_i[DELAY_W-1:0] == '0) begin
      delay_wr = DELAY_W'(1);
    end else if (32'(cfg_data_i[DELAY_W-1:0]) >= 32'(STORE_DEPTH)) begin
      delay_wr = DELAY_W'(STORE_DEPTH - 1);
    end else begin
      delay_wr = cfg_data_i[DELAY_W-1:0];
    end
  end

  // Read address of the entry one delay back, wrapped into the ring.
  assign warm_now = (warmup_q >= delay_q);
  assign wp_ext   = {1'b0, wp_q};
  assign d_ext    = (AW+1)'(delay_q);
  always_comb begin
    if (wp_ext >= d_ext) begin
      raddr_ext = wp_ext - d_ext;
    end else begin
      raddr_ext = wp_ext + (AW+1)'(STORE_DEPTH) - d_ext;
    end
  end
  assign raddr  = raddr_ext[AW-1:0];
  assign ram_we = (state_q == S_SUM);

  fde_ram #(
    .WIDTH (SW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sum_sat),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Multiplier schedule.
  always_comb begin
    mul_en = 1'b0;
    mul_op = MUL_DECAY;
    case (state_q)
      S_SCALE: begin
        mul_en = 1'b1;
        mul_op = MUL_DECAY;
      end
      S_RECIP: begin
        mul_en = 1'b1;
        mul_op = MUL_RECIP;
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_op = MUL_GAIN;
      end
      default: begin
        mul_en = 1'b0;
        mul_op = MUL_DECAY;
      end
    endcase
  end

  // The reciprocal step takes the magnitude straight from the decay product.
  fde_mul #(
    .SUM_BITS (SW)
  ) u_mul (
    .clk_i    (clk_i),
    .en_i     (mul_en),
    .op_i     (mul_op),
    .stored_i (signed'(rdata)),
    .decay_i  (decay_q),
    .mag_i    (mag_now),
    .sum_i    (sum_q),
    .gain_i   (gain_q),
    .p_o      (p)
  );

  // Magnitude of the decay product, divided by 100 through the reciprocal.
  assign p_low   = p[SW+7:0];
  assign mag_now = p_low[SW+7] ? MAG_W'(-p_low) : MAG_W'(p_low);

  // Reciprocal quotient may be one low: one compare and subtract fixes it.
  assign q0      = p[MAG_W +: SW];
  assign q0_x100 = MAG_W'(q0) * MAG_W'(DIVISOR);
  assign rem_raw = mag_q - q0_x100;
  assign adj     = (rem_raw >= MAG_W'(DIVISOR));
  assign rem_fix = adj ? (rem_raw - MAG_W'(DIVISOR)) : rem_raw;
  assign q_fix   = q0 + SW'(adj);
  assign fb_d    = neg_q ? -signed'(q_fix) : signed'(q_fix);

  // Sample plus feedback, saturated to the sum width.
  assign sum_ext = EXT_W'(sample_q) + (warm_q ? EXT_W'(fb_q) : EXT_W'(0));
  always_comb begin
    if (sum_ext > SUM_HI) begin
      sum_sat = SW'(SUM_HI);
    end else if (sum_ext < SUM_LO) begin
      sum_sat = SW'(SUM_LO);
    end else begin
      sum_sat = SW'(sum_ext);
    end
  end

  // Gain product, floor shift and output limiter.
  assign out_sh = p >>> GAIN_SHIFT;
  always_comb begin
    if (out_sh > OUT_HI) begin
      out_val  = SAMPLE_BITS'(CLIP_L);
      out_clip = 1'b1;
    end else if (out_sh < OUT_LO) begin
      out_val  = SAMPLE_BITS'(-CLIP_L);
      out_clip = 1'b1;
    end else begin
      out_val  = SAMPLE_BITS'(out_sh);
      out_clip = 1'b0;
    end
  end

  // Sequencer, configuration registers, pointers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_RESET;
      decay_q     <= DECAY_RESET;
      delay_q     <= DELAY_W'(DELAY_INIT);
      wp_q        <= '0;
      warmup_q    <= '0;
      warm_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_GAIN: begin
            gain_q   <= gain_wr;
            warmup_q <= '0;
          end
          CFG_DECAY: begin
            decay_q  <= decay_wr;
            warmup_q <= '0;
          end
          CFG_DELAY: begin
            delay_q  <= delay_wr;
            warmup_q <= '0;
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            warm_q  <= warm_now;
            state_q <= warm_now ? S_SCALE : S_SUM;
          end
        end
        S_SCALE: begin
          state_q <= S_RECIP;
        end
        S_RECIP: begin
          state_q <= S_FIX;
        end
        S_FIX: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          wp_q <= (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
          if (warmup_q != '1) begin
            warmup_q <= warmup_q + WARM_W'(1);
          end
          state_q <= S_GAIN;
        end
        S_GAIN: begin
          state_q <= S_LIMIT;
        end
        S_LIMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_sample_i;
    end
    if (state_q == S_RECIP) begin
      mag_q <= mag_now;
      neg_q <= p_low[SW+7];
    end
    if (state_q == S_FIX) begin
      fb_q <= fb_d;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_sat;
    end
    if (out_load) begin
      out_sample_q <= out_val;
      clipped_q    <= out_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o    = clipped_q;

  // The delay register never holds zero, so a read never hits the entry being written.
  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != '0)
    else $error("delay register holds zero");

  // After the one-step correction the remainder of the divide is below the divisor.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX) |-> (rem_fix < MAG_W'(DIVISOR)))
    else $error("reciprocal divide left a remainder of a full divisor or more");

  // A configuration write and a sample never land on the same edge.
  a_cfg_sample_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && cfg_acc))
    else $error("configuration write and sample accepted together");

  // A new result appears only out of the limiter step.
  a_out_from_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_LIMIT))
    else $error("output valid raised outside the limiter step");

  // Each stored sum advances the warm-up count off zero.
  a_warmup_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |=> (warmup_q != '0))
    else $error("warm-up count did not advance after a store");

endmodule

FILE: verif/feedback_delay_echo_core_test.sv
`timescale 1ns / 1ps

module feedback_delay_echo_core_test;
  import fde_pkg::*;

  localparam int     SAMPLE_W      = 16;
  localparam int     SUM_W         = 24;
  localparam int     DEPTH         = 65536;
  localparam longint SAMPLE_HI     = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO     = -SAMPLE_HI - 1;
  localparam longint SUM_HI        = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO        = -SUM_HI - 1;
  localparam longint CLIP_LIMIT    = ((longint'(1) << (SAMPLE_W - 1)) * 999) / 1000;
  localparam int     SETTLE_CYCLES = 10;
  localparam int     TAIL_CYCLES   = 20;
  localparam int     STALL_LIMIT   = 5000;
  localparam int     IDLE_PCT      = 35;
  localparam int     RANDOM_ITEMS  = 1300;
  localparam int     CALM_FIRST    = 300;
  localparam int     CALM_LAST     = 600;

  // Index past the end of the register list; the block takes it and ignores it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    WORD_SAMPLE,
    WORD_CONFIG,
    WORD_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e                   kind;
    logic signed [SAMPLE_W-1:0]   sample;
    logic [CFG_IDX_W-1:0]         index;
    logic [CFG_DATA_W-1:0]        data;
  } stim_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } echo_out_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic signed [SAMPLE_W-1:0]  in_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample_o;
  logic                        clipped_o;

  feedback_delay_echo_core #(
    .STORE_DEPTH(DEPTH),
    .SAMPLE_BITS(SAMPLE_W),
    .SUM_BITS   (SUM_W)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_sample_i (in_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_sample_o(out_sample_o),
    .clipped_o   (clipped_o)
  );

  // Stimulus waiting to be driven and echoes waiting to come back.
  stim_word_t stim_q[$];
  echo_out_t  echo_expect[$];

  // Shadow copy of the echo state and registers.
  longint          echo_mem [DEPTH];
  logic [15:0]     wr_ptr;
  logic [15:0]     warm_cnt;
  logic [GAIN_W-1:0]  gain_reg;
  logic [DECAY_W-1:0] decay_reg;
  logic [DELAY_W-1:0] delay_reg;

  int        issued     = 0;
  int        checked    = 0;
  int        settle     = 0;
  int        quiet      = 0;
  int        mismatches = 0;
  int        clip_seen  = 0;
  int        cfg_writes = 0;
  logic      tx_valid_nxt;
  logic      cfg_valid_nxt;
  echo_out_t check_word;

  // Works out the echoed word for one sample and advances the shadow state.
  function automatic echo_out_t echo_predict(logic signed [SAMPLE_W-1:0] s);
    echo_out_t   r;
    longint      gain;
    longint      decay;
    longint      sum;
    longint      prod;
    logic [15:0] d;
    logic [15:0] rd;
    gain  = (gain_reg > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_reg);
    decay = (decay_reg > DECAY_MAX) ? longint'(DECAY_MAX) : longint'(decay_reg);
    d     = (delay_reg == '0) ? 16'd1 : delay_reg;
    sum   = longint'(s);
    // Feedback only once warm-up has filled a whole delay line.
    if (warm_cnt >= d) begin
      rd  = wr_ptr - d;
      sum = sum + (echo_mem[rd] * decay) / DIVISOR;
    end
    if (sum > SUM_HI) begin
      sum = SUM_HI;
    end else if (sum < SUM_LO) begin
      sum = SUM_LO;
    end
    echo_mem[wr_ptr] = sum;
    wr_ptr = wr_ptr + 16'd1;
    if (warm_cnt != '1) begin
      warm_cnt = warm_cnt + 16'd1;
    end
    // Gain, floor shift and output limiter.
    prod      = (sum * gain) >>> GAIN_SHIFT;
    r.clipped = 1'b0;
    if (prod > SAMPLE_HI) begin
      prod      = CLIP_LIMIT;
      r.clipped = 1'b1;
    end else if (prod < SAMPLE_LO) begin
      prod      = -CLIP_LIMIT;
      r.clipped = 1'b1;
    end
    r.sample = prod[SAMPLE_W-1:0];
    return r;
  endfunction

  // A register write restarts warm-up; an unknown index changes nothing.
  function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN: begin
        gain_reg = data[GAIN_W-1:0];
        warm_cnt = '0;
      end
      CFG_DECAY: begin
        decay_reg = data[DECAY_W-1:0];
        warm_cnt  = '0;
      end
      CFG_DELAY: begin
        delay_reg = data[DELAY_W-1:0];
        warm_cnt  = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_sample(logic signed [SAMPLE_W-1:0] s);
    stim_word_t w;
    w.kind   = WORD_SAMPLE;
    w.sample = s;
    w.index  = '0;
    w.data   = '0;
    stim_q.push_back(w);
  endfunction

  function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_word_t w;
    w.kind   = WORD_CONFIG;
    w.sample = '0;
    w.index  = idx;
    w.data   = data;
    stim_q.push_back(w);
  endfunction

  function automatic void push_drain();
    stim_word_t w;
    w.kind   = WORD_DRAIN;
    w.sample = '0;
    w.index  = '0;
    w.data   = '0;
    stim_q.push_back(w);
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Driver: records accepted words, then offers the next sample or register write.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      issued      <= 0;
      settle      <= 0;
      wr_ptr      = '0;
      warm_cnt    = '0;
      gain_reg    = GAIN_RESET;
      decay_reg   = DECAY_RESET;
      delay_reg   = DELAY_W'(DELAY_RESET);
    end else begin
      if (in_valid_i && in_ready_o) begin
        echo_expect.push_back(echo_predict(in_sample_i));
        issued <= issued + 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_apply(cfg_index_i, cfg_data_i);
        cfg_writes <= cfg_writes + 1;
      end

      // Count quiet cycles once every echo is back and nothing is offered.
      if (issued == checked && !in_valid_i && !cfg_valid_i) begin
        if (settle < SETTLE_CYCLES) begin
          settle <= settle + 1;
        end
      end else begin
        settle <= 0;
      end

      if ((in_valid_i && !in_ready_o) || (cfg_valid_i && !cfg_ready_o)) begin
        tx_valid_nxt  = in_valid_i;
        cfg_valid_nxt = cfg_valid_i;
      end else begin
        tx_valid_nxt  = 1'b0;
        cfg_valid_nxt = 1'b0;
        if (stim_q.size() != 0) begin
          case (stim_q[0].kind)
            WORD_SAMPLE: begin
              if ((issued >= CALM_FIRST && issued < CALM_LAST) ||
                  $urandom_range(99) >= IDLE_PCT) begin
                tx_valid_nxt = 1'b1;
                in_sample_i  <= stim_q[0].sample;
                void'(stim_q.pop_front());
              end
            end
            WORD_CONFIG: begin
              if (settle >= SETTLE_CYCLES) begin
                cfg_valid_nxt = 1'b1;
                cfg_index_i   <= stim_q[0].index;
                cfg_data_i    <= stim_q[0].data;
                void'(stim_q.pop_front());
              end
            end
            default: begin
              if (settle >= SETTLE_CYCLES) begin
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
      end
      in_valid_i  <= tx_valid_nxt;
      cfg_valid_i <= cfg_valid_nxt;
    end
  end

  // Monitor: compares each accepted word with the oldest pending echo.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      checked     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (checked == issued) begin
          $error("unexpected word: out_sample %0d clipped %0b", out_sample_o, clipped_o);
          mismatches = mismatches + 1;
        end else begin
          check_word = echo_expect.pop_front();
          if (out_sample_o !== check_word.sample) begin
            $error("out_sample: expected %0d, actual %0d", check_word.sample, out_sample_o);
            mismatches = mismatches + 1;
          end
          if (clipped_o !== check_word.clipped) begin
            $error("clipped: expected %0b, actual %0b", check_word.clipped, clipped_o);
            mismatches = mismatches + 1;
          end
          if (check_word.clipped) begin
            clip_seen = clip_seen + 1;
          end
          checked <= checked + 1;
        end
      end
      out_ready_i <= (checked >= CALM_FIRST && checked < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int                         n_rand;
    int                         seg;
    logic [CFG_DATA_W-1:0]      val;
    logic signed [SAMPLE_W-1:0] smp;

    // Reset settings: warm-up passes the sample at unity gain.
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0000);
    push_sample(-16'sd1);
    push_sample(16'sd1);

    // Full gain, strongest decay, shortest delay: both clip directions.
    push_cfg(CFG_GAIN, GAIN_MAX);
    push_cfg(CFG_DECAY, CFG_DATA_W'(DECAY_MAX));
    push_cfg(CFG_DELAY, 16'd1);
    repeat (3) push_sample(16'sh7FFF);
    repeat (3) push_sample(16'sh8000);

    // Over-range gain and decay saturate, zero delay acts as one.
    push_cfg(CFG_GAIN, 16'hFFFF);
    push_cfg(CFG_DECAY, 16'hFFFF);
    push_cfg(CFG_DELAY, 16'd0);
    push_sample(16'sh8000);
    push_sample(16'sd16384);
    push_sample(16'sd1);

    // Write to an unknown index must not restart warm-up.
    push_cfg(CFG_UNUSED, 16'hFFFF);
    push_sample(16'sd100);
    push_sample(-16'sd100);

    // Zero gain and decay with the longest delay.
    push_cfg(CFG_GAIN, 16'd0);
    push_cfg(CFG_DECAY, 16'd0);
    push_cfg(CFG_DELAY, 16'hFFFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);

    // Half decay over a short delay line.
    push_cfg(CFG_GAIN, GAIN_RESET);
    push_cfg(CFG_DECAY, 16'd50);
    push_cfg(CFG_DELAY, 16'd3);
    push_sample(16'sd20000);
    push_sample(-16'sd20000);
    push_sample(16'sh7FFF);
    push_sample(16'sd12345);
    push_sample(-16'sd1);
    push_sample(16'sh8000);

    // Random segments, each behind a fresh mix of register settings.
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        push_cfg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       val = '0;
          1:       val = GAIN_MAX;
          2:       val = CFG_DATA_W'($urandom_range(65535, 32769));
          default: val = CFG_DATA_W'($urandom_range(32768));
        endcase
        push_cfg(CFG_GAIN, val);
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       val = '0;
          1:       val = CFG_DATA_W'(DECAY_MAX);
          2:       val = CFG_DATA_W'($urandom);
          default: val = CFG_DATA_W'($urandom_range(99));
        endcase
        push_cfg(CFG_DECAY, val);
      end
      if ($urandom_range(1) == 1) begin
        // Mostly short delays so that feedback starts within the segment.
        case ($urandom_range(19))
          0:          val = '0;
          1:          val = 16'hFFFF;
          2, 3, 4, 5: val = CFG_DATA_W'($urandom_range(400, 33));
          default:    val = CFG_DATA_W'($urandom_range(32, 1));
        endcase
        push_cfg(CFG_DELAY, val);
      end
      seg = $urandom_range(120, 40);
      for (int k = 0; k < seg; k++) begin
        if ($urandom_range(49) == 0) begin
          push_drain();
        end
        case ($urandom_range(9))
          0:       smp = 16'sh7FFF;
          1:       smp = 16'sh8000;
          2:       smp = SAMPLE_W'($urandom_range(200) - 100);
          default: smp = SAMPLE_W'($urandom);
        endcase
        push_sample(smp);
      end
      n_rand = n_rand + seg;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the stimulus to run out and every echo to come back.
    do begin
      @(negedge clk_i);
    end while (stim_q.size() != 0 || in_valid_i || cfg_valid_i || issued != checked);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Checked %0d echoed samples, %0d of them limited, over %0d register writes.",
             checked, clip_seen, cfg_writes);
    $display("Run covered warm-up, feedback, gain and decay extremes and delays 0 to 65535.");
    if (mismatches == 0 && issued == checked) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fde_pkg.sv
sv/fde_ram.sv
sv/fde_mul.sv
sv/feedback_delay_echo_core.sv
verif/feedback_delay_echo_core_test.sv
